### rtl/rdst_pkg.sv
// Shared types and constants for the row dirty span tracker.
`default_nettype none

package rdst_pkg;

    // Column field width and its largest value
    localparam int COL_W = 11;
    localparam logic [COL_W-1:0] COL_FIELD_MAX = 11'd2047;

    // Rows reachable through the 8-bit row field
    localparam int ROW_FIELD_ROWS = 256;

    // Register reset values
    localparam logic [8:0]       ROW_COUNT_RESET    = 9'd24;
    localparam logic [COL_W-1:0] COLUMN_COUNT_RESET = 11'd80;

    // Register indexes
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;

    // Operation codes; the unused code behaves as a query
    typedef enum logic [1:0] {
        OP_TAINT   = 2'd0,
        OP_CLEANSE = 2'd1,
        OP_QUERY   = 2'd2
    } op_t;

    // One column span [first, limit)
    typedef struct packed {
        logic [COL_W-1:0] first;
        logic [COL_W-1:0] limit;
    } span_t;

endpackage

`default_nettype wire

### rtl/rdst_span_mem.sv
// Span store: one-write, one-read synchronous RAM with registered read data.
`default_nettype none

module rdst_span_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire rdst_pkg::span_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output rdst_pkg::span_t      rdata
);

    rdst_pkg::span_t mem [DEPTH];
    rdst_pkg::span_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/rdst_span_alu.sv
// Span update logic: taint, cleanse and query of one row's span.
`default_nettype none

module rdst_span_alu (
    input  wire logic [1:0]                 op,
    input  wire rdst_pkg::span_t            cur,
    input  wire rdst_pkg::span_t            given,
    input  wire logic [rdst_pkg::COL_W-1:0] cols,
    output rdst_pkg::span_t                 upd,
    output logic                            changed
);

    rdst_pkg::span_t raw;
    logic            norm;

    always_comb
    begin
        raw  = cur;
        norm = 1'b0;
        case (op)
            rdst_pkg::OP_TAINT:
            begin
                raw.first = (cur.first < given.first) ? cur.first : given.first;
                raw.limit = (cur.limit > given.limit) ? cur.limit : given.limit;
                if (raw.limit > cols)
                begin
                    raw.limit = cols;
                end
                norm = 1'b1;
            end
            rdst_pkg::OP_CLEANSE:
            begin
                // trim only the edges that the given span covers
                if (given.first <= cur.first)
                begin
                    raw.first = (cur.first > given.limit) ? cur.first : given.limit;
                end
                if (given.limit >= cur.limit)
                begin
                    raw.limit = (cur.limit < given.first) ? cur.limit : given.first;
                end
                norm = 1'b1;
            end
            default:
            begin
                raw  = cur;
                norm = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        upd = raw;
        if (norm && (raw.first >= raw.limit))
        begin
            upd = '0;
        end
    end

    assign changed = (upd.first != cur.first) || (upd.limit != cur.limit);

endmodule

`default_nettype wire

### rtl/row_dirty_span_tracker_top.sv
// Top level of the row dirty span tracker: handshakes, row state RAM and forwarding.
`default_nettype none

// Channel   Dir  Signals                      Contents (lowest bit up)
// s_*       in   s_tvalid s_tready s_tdata    row_index[7:0] span_first[18:8]
//                s_tuser                      span_limit[29:19]; tuser opcode[1:0]
// m_*       out  m_tvalid m_tready m_tdata    dirty_first[10:0] dirty_limit[21:11]
//                m_tuser                      tuser span_changed[0] row_error[1]
// cfg_*     in   cfg_we cfg_index cfg_data    0 row_count, 1 column_count
//
// Each transaction passes the RAM read, then update, write-back and output
// register. One transaction per cycle is taken sustained while the output is
// not stalled; a write on the edge that issues a read of the same row is forwarded.
// After reset or any register write every row reads as 0..columns at once:
// a valid bit per row selects between RAM contents and that default.
// A stalled output holds the update stage; input backs up one stage later.

module row_dirty_span_tracker_top #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input transactions
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // row_index, span_first, span_limit, zero pad
    input  wire logic [1:0]  s_tuser,   // opcode
    // result transactions
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // dirty_first, dirty_limit, zero pad
    output logic [1:0]       m_tuser,   // span_changed, row_error
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    // Only rows the 8-bit field can name need storage
    localparam int DEPTH = (MAX_ROWS < rdst_pkg::ROW_FIELD_ROWS) ?
                           MAX_ROWS : rdst_pkg::ROW_FIELD_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [12:0] ROW_CAP = 13'(MAX_ROWS);
    localparam logic [rdst_pkg::COL_W-1:0] COL_CAP =
        (MAX_COLS > 2047) ? rdst_pkg::COL_FIELD_MAX : 11'(MAX_COLS);

    // configuration registers
    logic [8:0]                 row_count_reg;
    logic [rdst_pkg::COL_W-1:0] column_count_reg;
    logic                       cfg_hit;

    // saturated counts
    logic [12:0]                eff_rows;
    logic [rdst_pkg::COL_W-1:0] eff_cols;

    // input decode
    logic [7:0]      in_row;
    rdst_pkg::span_t in_given;
    logic            in_row_ok;
    logic            accept;

    // read stage
    logic            s1_valid_reg;
    logic [1:0]      s1_op_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic            s1_row_ok_reg;
    rdst_pkg::span_t s1_given_reg;
    logic            advance;

    // row state
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    rdst_pkg::span_t  mem_rdata;
    logic             wr_en;

    // last write, for a read issued on the same edge
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    rdst_pkg::span_t  fwd_span_reg;

    // update
    rdst_pkg::span_t cur_span;
    rdst_pkg::span_t upd_span;
    logic            upd_changed;

    // output register
    logic            out_valid_reg;
    rdst_pkg::span_t out_span_reg;
    logic            out_changed_reg;
    logic            out_error_reg;

    assign cfg_hit = cfg_we && ((cfg_index == rdst_pkg::CFG_ROW_COUNT) ||
                                (cfg_index == rdst_pkg::CFG_COLUMN_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= rdst_pkg::ROW_COUNT_RESET;
            column_count_reg <= rdst_pkg::COLUMN_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rdst_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data[8:0];
                rdst_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign eff_rows = ({4'b0, row_count_reg} > ROW_CAP) ? ROW_CAP : {4'b0, row_count_reg};
    assign eff_cols = (column_count_reg > COL_CAP) ? COL_CAP : column_count_reg;

    assign in_row         = s_tdata[7:0];
    assign in_given.first = s_tdata[18:8];
    assign in_given.limit = s_tdata[29:19];
    assign in_row_ok      = ({5'b0, in_row} < eff_rows);

    // input stalls only behind a held read stage
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= s_tuser;
            s1_addr_reg   <= in_row[AW-1:0];
            s1_row_ok_reg <= in_row_ok;
            s1_given_reg  <= in_given;
        end
    end

    rdst_span_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (upd_span),
        .re    (accept),
        .raddr (in_row[AW-1:0]),
        .rdata (mem_rdata)
    );

    // forwarded write wins, then RAM if the row was written, else full dirty
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur_span = fwd_span_reg;
        end
        else if (valid_reg[s1_addr_reg])
        begin
            cur_span = mem_rdata;
        end
        else
        begin
            cur_span.first = '0;
            cur_span.limit = eff_cols;
        end
    end

    rdst_span_alu u_alu (
        .op      (s1_op_reg),
        .cur     (cur_span),
        .given   (s1_given_reg),
        .cols    (eff_cols),
        .upd     (upd_span),
        .changed (upd_changed)
    );

    // rows out of range leave the state alone
    assign wr_en = s1_valid_reg && advance && s1_row_ok_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cfg_hit)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_hit)
            begin
                fwd_valid_reg <= 1'b0;
            end
            else if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_span_reg <= upd_span;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_span_reg    <= s1_row_ok_reg ? upd_span : '0;
            out_changed_reg <= s1_row_ok_reg && upd_changed;
            out_error_reg   <= !s1_row_ok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b0, out_span_reg.limit, out_span_reg.first};
    assign m_tuser  = {out_error_reg, out_changed_reg};

endmodule

`default_nettype wire

### rtl/rdst_checker.sv
// Port-level checks on the row dirty span tracker, bound to its top level.
`default_nettype none

module rdst_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result holds valid and payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // an out-of-range row reports an empty, unchanged span
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> ((m_tdata == 24'd0) && !m_tuser[0]))
        else $error("row error with non-zero result");

    // a reported span is either proper or the clean form 0,0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[10:0] < m_tdata[21:11]) ||
                      ((m_tdata[10:0] == 11'd0) && (m_tdata[21:11] == 11'd0))))
        else $error("malformed span");

    // with the output free the input is never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind row_dirty_span_tracker_top rdst_checker u_rdst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
